>>> rtl/vfu_pkg.sv
// ----------------------------------------------------------------------------
// Vector unit package
// Opcode codes and shared control types of the three-component vector unit.
// ----------------------------------------------------------------------------
package vfu_pkg;

	localparam int OPCODE_WIDTH = 4;

	typedef logic [OPCODE_WIDTH-1:0] opcode_t;

	localparam opcode_t OP_NORM   = 4'd0;
	localparam opcode_t OP_SCALE  = 4'd1;
	localparam opcode_t OP_NEG    = 4'd2;
	localparam opcode_t OP_DIR    = 4'd3;
	localparam opcode_t OP_LEN    = 4'd4;
	localparam opcode_t OP_LENSQ  = 4'd5;
	localparam opcode_t OP_DIST   = 4'd6;
	localparam opcode_t OP_DISTSQ = 4'd7;
	localparam opcode_t OP_SUB    = 4'd8;
	localparam opcode_t OP_CROSS  = 4'd9;
	localparam opcode_t OP_DOT    = 4'd10;
	localparam opcode_t OP_LERP   = 4'd11;

	// Control of one lane: pipeline advance and the sign of the second product.
	typedef struct packed {
		logic en;
		logic sub;
	} lane_ctl_t;

endpackage

>>> rtl/vfu_if.sv
// ----------------------------------------------------------------------------
// Vector unit channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface vfu_req_if #(parameter int W = 32);
	logic             valid;
	logic             ready;
	vfu_pkg::opcode_t opcode;
	logic signed [W-1:0] ax;
	logic signed [W-1:0] ay;
	logic signed [W-1:0] az;
	logic signed [W-1:0] bx;
	logic signed [W-1:0] by;
	logic signed [W-1:0] bz;
	logic signed [W-1:0] factor;

	modport source(output valid, opcode, ax, ay, az, bx, by, bz, factor, input ready);
	modport sink(input valid, opcode, ax, ay, az, bx, by, bz, factor, output ready);
endinterface

interface vfu_rsp_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] rx;
	logic signed [W-1:0] ry;
	logic signed [W-1:0] rz;
	logic signed [W-1:0] scalar;
	logic saturated;
	logic zero_length;

	modport source(output valid, rx, ry, rz, scalar, saturated, zero_length, input ready);
	modport sink(input valid, rx, ry, rz, scalar, saturated, zero_length, output ready);
endinterface

>>> rtl/vfu_lane.sv
// ----------------------------------------------------------------------------
// Vector unit lane
// Two signed products, registered, then their sum or difference, registered.
// ----------------------------------------------------------------------------
module vfu_lane #(
	parameter int OW = 34
) (
	input  logic                  clk,
	input  vfu_pkg::lane_ctl_t    ctl,
	input  logic signed [OW-1:0]  m0,
	input  logic signed [OW-1:0]  m1,
	input  logic signed [OW-1:0]  m2,
	input  logic signed [OW-1:0]  m3,
	output logic signed [2*OW:0]  sum
);

	logic signed [2*OW-1:0] p_s2;
	logic signed [2*OW-1:0] q_s2;
	logic                   sub_s2;
	logic signed [2*OW:0]   sum_s3;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			p_s2   <= m0 * m1;
			q_s2   <= m2 * m3;
			sub_s2 <= ctl.sub;
			if (sub_s2) begin
				sum_s3 <= (2*OW+1)'(p_s2) - (2*OW+1)'(q_s2);
			end else begin
				sum_s3 <= (2*OW+1)'(p_s2) + (2*OW+1)'(q_s2);
			end
		end
	end

	assign sum = sum_s3;

endmodule

>>> rtl/vfu_sqrt.sv
// ----------------------------------------------------------------------------
// Vector unit square root
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vfu_sqrt #(
	parameter int RW = 33
) (
	input  logic              clk,
	input  logic              en,
	input  logic [2*RW-1:0]   rad,
	output logic [RW-1:0]     root
);

	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] rad_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+1:0]   prev_rem;
		logic [RW-1:0]   prev_root;
		logic [2*RW-1:0] prev_rad;
		logic [RW+3:0]   rem_ext;
		logic [RW+3:0]   trial;

		if (k == 0) begin : g_first
			assign prev_rem  = '0;
			assign prev_root = '0;
			assign prev_rad  = rad;
		end else begin : g_next
			assign prev_rem  = rem_s[k-1];
			assign prev_root = root_s[k-1];
			assign prev_rad  = rad_s[k-1];
		end

		assign rem_ext = {prev_rem, prev_rad[2*RW-1 -: 2]};
		assign trial   = {2'b00, prev_root, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= {prev_rad[2*RW-3:0], 2'b00};
				if (rem_ext >= trial) begin
					rem_s[k]  <= (RW+2)'(rem_ext - trial);
					root_s[k] <= {prev_root[RW-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_ext[RW+1:0];
					root_s[k] <= {prev_root[RW-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[RW-1];

endmodule

>>> rtl/vfu_div.sv
// ----------------------------------------------------------------------------
// Vector unit divider
// Pipelined restoring division of a magnitude scaled by 1.0 by a length.
// ----------------------------------------------------------------------------
module vfu_div #(
	parameter int RW = 33,
	parameter int F  = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] len,
	input  logic [RW-1:0] mag,
	output logic [F:0]    quo,
	output logic [RW-1:0] len_o
);

	// The magnitude never exceeds the length, so the quotient fits F+1 bits and
	// the first partial remainder is the magnitude shifted right by one.
	logic [RW-1:0] rem_s [F+1];
	logic [F:0]    quo_s [F+1];
	logic [RW-1:0] len_s [F+1];

	for (genvar k = 0; k <= F; k++) begin : g_stage
		logic [RW-1:0] prev_rem;
		logic [F:0]    prev_quo;
		logic [RW-1:0] prev_len;
		logic          bit_in;
		logic [RW:0]   rem_ext;

		if (k == 0) begin : g_first
			assign prev_rem = mag >> 1;
			assign prev_quo = '0;
			assign prev_len = len;
			assign bit_in   = mag[0];
		end else begin : g_next
			assign prev_rem = rem_s[k-1];
			assign prev_quo = quo_s[k-1];
			assign prev_len = len_s[k-1];
			assign bit_in   = 1'b0;
		end

		assign rem_ext = {prev_rem, bit_in};

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[k] <= prev_len;
				if (rem_ext >= {1'b0, prev_len}) begin
					rem_s[k] <= RW'(rem_ext - {1'b0, prev_len});
					quo_s[k] <= {prev_quo[F-1:0], 1'b1};
				end else begin
					rem_s[k] <= rem_ext[RW-1:0];
					quo_s[k] <= {prev_quo[F-1:0], 1'b0};
				end
			end
		end
	end

	assign quo   = quo_s[F];
	assign len_o = len_s[F];

endmodule

>>> rtl/vector3_fixed_point_unit.sv
// ----------------------------------------------------------------------------
// Three-component fixed-point vector unit
// Signed fixed-point vector operations on a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Each request transaction carries an opcode, two vectors a and b and a factor,
// and yields exactly one response transaction. The unit accepts one transaction
// per clock and returns results in order; each response passes through the
// square-root pipeline, which resolves one root bit per stage, followed by the
// normalizing divider, which resolves one quotient bit per stage. When a
// finished response is not taken, the whole pipeline holds and the request
// side stops accepting until the response goes.
// Products are floored to FRACTION_BITS fraction bits and clamped with the
// saturated flag; normalizing a zero vector returns zero with zero_length set.
// ----------------------------------------------------------------------------
module vector3_fixed_point_unit #(
	parameter int COMPONENT_WIDTH = 32,
	parameter int FRACTION_BITS   = 16
) (
	input logic       clk,
	input logic       arst_n,
	vfu_req_if.sink   req,
	vfu_rsp_if.source rsp
);

	localparam int W  = COMPONENT_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int OW = W + 2;          // operand width: differences and 1 - t
	localparam int SW = 2 * OW + 1;     // lane sum width
	localparam int TW = SW + 2;         // three-lane total width
	localparam int RW = W + 1;          // root and magnitude width
	localparam int D  = RW + F + 1;     // root plus divider depth
	localparam int NV = 4 + D;          // stages ahead of the output register

	localparam logic signed [OW-1:0] FX_ONE = OW'(1) << F;
	localparam logic signed [W-1:0]  W_MAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  W_MIN  = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		vfu_pkg::opcode_t     op;
		logic [2:0][W-1:0]    fx;
		logic                 fsat;
		logic [W-1:0]         sfix;
		logic                 ssat;
		logic [2:0][RW-1:0]   mag;
		logic [2:0]           neg;
	} tail_t;

	// Floor to the fixed-point grid and clamp; the top bit is the saturation flag.
	function automatic logic [W:0] fix_sat(input logic signed [TW-1:0] x);
		logic signed [TW-1:0] sh;
		begin
			sh = x >>> F;
			if (sh > TW'(W_MAX)) begin
				fix_sat = {1'b1, W_MAX};
			end else if (sh < TW'(W_MIN)) begin
				fix_sat = {1'b1, W_MIN};
			end else begin
				fix_sat = {1'b0, sh[W-1:0]};
			end
		end
	endfunction

	// The pipeline advances whenever the output register is free or being emptied.
	logic en;
	logic out_v_q;
	logic [NV-1:0] vld_q;

	assign en        = !out_v_q || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			vld_q   <= {vld_q[NV-2:0], req.valid};
			out_v_q <= vld_q[NV-1];
		end
	end

	// Operand extension and the differences used by direction and distance.
	logic signed [OW-1:0] a_e  [3];
	logic signed [OW-1:0] b_e  [3];
	logic signed [OW-1:0] d_ab [3];
	logic signed [OW-1:0] d_ba [3];
	logic signed [OW-1:0] t_e;
	logic signed [OW-1:0] omt;

	assign a_e[0] = OW'(req.ax);
	assign a_e[1] = OW'(req.ay);
	assign a_e[2] = OW'(req.az);
	assign b_e[0] = OW'(req.bx);
	assign b_e[1] = OW'(req.by);
	assign b_e[2] = OW'(req.bz);
	assign t_e    = OW'(req.factor);
	assign omt    = FX_ONE - t_e;

	vfu_pkg::lane_ctl_t   ctl [3];
	logic signed [SW-1:0] sum_s3 [3];
	vfu_pkg::opcode_t     op_s1, op_s2, op_s3, op_s4;
	logic [2:0][RW-1:0]   mag_s1, mag_s2, mag_s3, mag_s4;
	logic [2:0]           neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2:0][W-1:0]    fx_s4;
	logic [2:0]           fsat_s4;
	logic signed [TW-1:0] total_s4;

	// Each lane picks its two products from the opcode; the cross product rotates
	// the component indexes so that every lane forms one term of a x b.
	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int I1 = (i + 1) % 3;
		localparam int I2 = (i + 2) % 3;

		logic signed [OW-1:0] m0, m1, m2, m3, vec;
		logic                 sub;
		logic signed [OW-1:0] m0_s1, m1_s1, m2_s1, m3_s1;
		logic                 sub_s1;

		always_comb begin
			m0  = '0;
			m1  = '0;
			m2  = '0;
			m3  = '0;
			sub = 1'b0;
			vec = '0;
			case (req.opcode) inside
				vfu_pkg::OP_NORM, vfu_pkg::OP_LEN, vfu_pkg::OP_LENSQ: begin
					vec = a_e[i];
					m0  = a_e[i];
					m1  = a_e[i];
				end
				vfu_pkg::OP_DIR: begin
					vec = d_ba[i];
					m0  = d_ba[i];
					m1  = d_ba[i];
				end
				vfu_pkg::OP_DIST, vfu_pkg::OP_DISTSQ: begin
					vec = d_ab[i];
					m0  = d_ab[i];
					m1  = d_ab[i];
				end
				vfu_pkg::OP_SCALE: begin
					m0 = a_e[i];
					m1 = t_e;
				end
				vfu_pkg::OP_NEG: begin
					m0 = a_e[i];
					m1 = -FX_ONE;
				end
				vfu_pkg::OP_SUB: begin
					m0  = a_e[i];
					m1  = FX_ONE;
					m2  = b_e[i];
					m3  = FX_ONE;
					sub = 1'b1;
				end
				vfu_pkg::OP_CROSS: begin
					m0  = a_e[I1];
					m1  = b_e[I2];
					m2  = a_e[I2];
					m3  = b_e[I1];
					sub = 1'b1;
				end
				vfu_pkg::OP_DOT: begin
					m0 = a_e[i];
					m1 = b_e[i];
				end
				vfu_pkg::OP_LERP: begin
					m0 = a_e[i];
					m1 = omt;
					m2 = b_e[i];
					m3 = t_e;
				end
				default: begin
				end
			endcase
		end

		assign d_ab[i] = a_e[i] - b_e[i];
		assign d_ba[i] = b_e[i] - a_e[i];

		always_ff @(posedge clk) begin
			if (en) begin
				m0_s1     <= m0;
				m1_s1     <= m1;
				m2_s1     <= m2;
				m3_s1     <= m3;
				sub_s1    <= sub;
				neg_s1[i] <= vec[OW-1];
				mag_s1[i] <= vec[OW-1] ? RW'(-vec) : RW'(vec);
			end
		end

		assign ctl[i] = '{en: en, sub: sub_s1};

		vfu_lane #(.OW(OW)) u_lane (
			.clk (clk),
			.ctl (ctl[i]),
			.m0  (m0_s1),
			.m1  (m1_s1),
			.m2  (m2_s1),
			.m3  (m3_s1),
			.sum (sum_s3[i])
		);

		logic [W:0] fixed;
		assign fixed = fix_sat(TW'(sum_s3[i]));

		always_ff @(posedge clk) begin
			if (en) begin
				fx_s4[i]   <= fixed[W-1:0];
				fsat_s4[i] <= fixed[W];
			end
		end
	end

	// Merge stage: the three lane sums form the dot product, squared length or squared distance.
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= req.opcode;
			op_s2    <= op_s1;
			op_s3    <= op_s2;
			op_s4    <= op_s3;
			mag_s2   <= mag_s1;
			mag_s3   <= mag_s2;
			mag_s4   <= mag_s3;
			neg_s2   <= neg_s1;
			neg_s3   <= neg_s2;
			neg_s4   <= neg_s3;
			total_s4 <= TW'(sum_s3[0]) + TW'(sum_s3[1]) + TW'(sum_s3[2]);
		end
	end

	// Everything but the root and quotient rides a delay line alongside them.
	logic [W:0] sfixed;
	tail_t      tail_q [D];

	assign sfixed = fix_sat(total_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			tail_q[0] <= '{op: op_s4, fx: fx_s4, fsat: |fsat_s4, sfix: sfixed[W-1:0],
				ssat: sfixed[W], mag: mag_s4, neg: neg_s4};
			for (int k = 1; k < D; k++) begin
				tail_q[k] <= tail_q[k-1];
			end
		end
	end

	logic [RW-1:0] root;

	vfu_sqrt #(.RW(RW)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (total_s4[2*RW-1:0]),
		.root (root)
	);

	logic [F:0]    quo  [3];
	logic [RW-1:0] lens [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		vfu_div #(.RW(RW), .F(F)) u_div (
			.clk   (clk),
			.en    (en),
			.len   (root),
			.mag   (tail_q[RW-1].mag[i]),
			.quo   (quo[i]),
			.len_o (lens[i])
		);
	end

	// Final selection of the response fields.
	tail_t               tl;
	logic [RW-1:0]       len_fin;
	logic [RW-1:0]       root_fin;
	logic signed [W-1:0] r_d [3];
	logic signed [W-1:0] sc_d;
	logic                sat_d;
	logic                zl_d;
	logic signed [W-1:0] r_q [3];
	logic signed [W-1:0] sc_q;
	logic                sat_q;
	logic                zl_q;

	assign tl       = tail_q[D-1];
	assign len_fin  = lens[0];
	assign root_fin = lens[1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_d[i] = '0;
		end
		sc_d  = '0;
		sat_d = 1'b0;
		zl_d  = 1'b0;
		case (tl.op) inside
			vfu_pkg::OP_NORM, vfu_pkg::OP_DIR: begin
				if (len_fin == '0) begin
					zl_d = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						r_d[i] = tl.neg[i] ? -W'(quo[i]) : W'(quo[i]);
					end
				end
			end
			vfu_pkg::OP_LEN, vfu_pkg::OP_DIST: begin
				if (root_fin > RW'(W_MAX)) begin
					sc_d  = W_MAX;
					sat_d = 1'b1;
				end else begin
					sc_d = root_fin[W-1:0];
				end
			end
			vfu_pkg::OP_LENSQ, vfu_pkg::OP_DISTSQ, vfu_pkg::OP_DOT: begin
				sc_d  = tl.sfix;
				sat_d = tl.ssat;
			end
			vfu_pkg::OP_SCALE, vfu_pkg::OP_NEG, vfu_pkg::OP_SUB, vfu_pkg::OP_CROSS,
			vfu_pkg::OP_LERP: begin
				for (int i = 0; i < 3; i++) begin
					r_d[i] = tl.fx[i];
				end
				sat_d = tl.fsat;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q   <= r_d;
			sc_q  <= sc_d;
			sat_q <= sat_d;
			zl_q  <= zl_d;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.rx          = r_q[0];
	assign rsp.ry          = r_q[1];
	assign rsp.rz          = r_q[2];
	assign rsp.scalar      = sc_q;
	assign rsp.saturated   = sat_q;
	assign rsp.zero_length = zl_q;

`ifndef SYNTHESIS
	// A zero-length normalize returns the zero vector and never saturates.
	a_zero_len_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.zero_length |->
		rsp.rx == '0 && rsp.ry == '0 && rsp.rz == '0 && !rsp.saturated)
		else $error("zero_length response carries data");

	// Scalar results come with a zero vector.
	a_scalar_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.scalar != '0 |-> rsp.rx == '0 && rsp.ry == '0 && rsp.rz == '0)
		else $error("scalar and vector results both nonzero");

	// A request taken while the pipeline is full of work cannot vanish: the
	// stage after the input is loaded at that edge.
	a_intake: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_q[0])
		else $error("accepted transaction not captured");
`endif

endmodule
